// ===== rtl/block_request_tag_queue_top_macros.svh =====
`ifndef BLOCK_REQUEST_TAG_QUEUE_TOP_MACROS_SVH
`define BLOCK_REQUEST_TAG_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define BRTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/brtq_pkg.sv =====
`default_nettype none

package brtq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 64;

  localparam int unsigned TAG_W   = 6;
  localparam int unsigned POS_W   = 48;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned RAW_W   = 8;

  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd12;

  localparam logic [RAW_W-1:0] RAW_READ         = 8'd0;
  localparam logic [RAW_W-1:0] RAW_WRITE        = 8'd1;
  localparam logic [RAW_W-1:0] RAW_FLUSH        = 8'd2;
  localparam logic [RAW_W-1:0] RAW_DISCARD      = 8'd3;
  localparam logic [RAW_W-1:0] RAW_WRITE_ZEROES = 8'd9;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_PEEK,
    CMD_POP
  } cmd_t;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_DISCARD
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FLUSH,
    ST_UNSUP,
    ST_NO_TAG,
    ST_EMPTY
  } status_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/brtq_if.sv =====
`default_nettype none

interface brtq_in_if import brtq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [RAW_W-1:0] request_op;
  logic [POS_W-1:0] sector;
  logic [LEN_W-1:0] byte_length_in;
  logic [TAG_W-1:0] tag_in;

  modport source (
    output valid, command, request_op, sector, byte_length_in, tag_in,
    input  ready
  );
  modport sink (
    input  valid, command, request_op, sector, byte_length_in, tag_in,
    output ready
  );
endinterface

interface brtq_out_if import brtq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [TAG_W-1:0] tag_out;
  logic [1:0]       op_out;
  logic             is_rw;
  logic [POS_W-1:0] block_pos;
  logic [LEN_W-1:0] byte_length_out;

  modport source (
    output valid, status, tag_out, op_out, is_rw, block_pos, byte_length_out,
    input  ready
  );
  modport sink (
    input  valid, status, tag_out, op_out, is_rw, block_pos, byte_length_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/block_request_tag_queue_top.sv =====
// Request tag queue. Push takes the oldest free tag, records the request
// descriptor under it and queues the tag as pending; peek dequeues the oldest
// pending tag with its descriptor; pop returns a tag to the free list. One item
// is accepted every cycle while results are taken. The input register feeds the
// pointer and classify logic, whose outcome lands in the result register beside
// the registered descriptor-memory read. With the output held off, input stalls
// once the input and result registers both hold an item. Ring heads are
// prefetched from their memories, so back-to-back items see each other's
// updates. The user must write block_shift only while no item is in flight;
// the block itself does not enforce this.
`default_nettype none

`include "block_request_tag_queue_top_macros.svh"

module block_request_tag_queue_top import brtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_data,
  brtq_in_if.sink            req,
  brtq_out_if.source         rsp
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = (IW > TAG_W) ? IW : TAG_W;

  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] N_CNT    = CW'(QUEUE_DEPTH);
  localparam logic [EW:0]   N_EXT    = (EW + 1)'(QUEUE_DEPTH);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TAG_W-1:0] tag_narrow(input logic [IW-1:0] t);
    logic [EW-1:0] e;
    e = EW'(t);
    return e[TAG_W-1:0];
  endfunction

  logic [SHIFT_W-1:0] block_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift <= BLOCK_SHIFT_RST;
    end else if (cfg_we) begin
      block_shift <= cfg_data;
    end
  end

  // input register
  logic             s1_valid;
  logic [1:0]       q_cmd;
  logic [RAW_W-1:0] q_rop;
  logic [POS_W-1:0] q_sector;
  logic [LEN_W-1:0] q_len;
  logic [TAG_W-1:0] q_tag;

  logic s2_valid;
  logic adv;

  assign adv       = s1_valid && (!s2_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_cmd    <= req.command;
      q_rop    <= req.request_op;
      q_sector <= req.sector;
      q_len    <= req.byte_length_in;
      q_tag    <= req.tag_in;
    end
  end

  // queue state
  logic [IW-1:0] free_head, free_head_next;
  logic [IW-1:0] free_tail, free_tail_next;
  logic          free_wrapped, free_wrapped_next;
  logic [CW-1:0] free_count, free_count_next;
  logic [IW-1:0] pend_head, pend_head_next;
  logic [IW-1:0] pend_tail, pend_tail_next;
  logic [CW-1:0] pend_count, pend_count_next;

  logic [IW-1:0] free_rdata;
  logic [IW-1:0] pend_head_tag;
  logic [IW-1:0] free_head_tag;
  logic          free_written;

  // free ring entries not yet overwritten hold no tag; their own index is used as the tag
  assign free_written  = free_wrapped || (free_head < free_tail);
  assign free_head_tag = free_written ? free_rdata : free_head;

  // classify and decide
  status_t          st;
  logic             grant;
  logic             free_push;
  logic             pend_pop;
  logic             from_desc;
  logic             op_ok;
  op_t              op_c;
  logic [TAG_W-1:0] res_tag;
  logic [1:0]       res_op;
  logic             res_is_rw;
  logic [POS_W-1:0] res_pos;
  logic [LEN_W-1:0] res_len;
  logic [POS_W+8:0] pos_wide;
  logic [POS_W-1:0] pos_c;
  logic [EW-1:0]    tin_ext;

  assign pos_wide = {q_sector, 9'd0} >> block_shift;
  assign pos_c    = pos_wide[POS_W-1:0];
  assign tin_ext  = EW'(q_tag);

  always_comb begin
    st        = ST_OK;
    grant     = 1'b0;
    free_push = 1'b0;
    pend_pop  = 1'b0;
    from_desc = 1'b0;
    op_ok     = 1'b0;
    op_c      = OP_READ;
    res_tag   = '0;
    res_op    = '0;
    res_is_rw = 1'b0;
    res_pos   = '0;
    res_len   = '0;
    case (q_cmd)
      CMD_PUSH: begin
        if (q_rop == RAW_READ) begin
          op_ok = 1'b1;
          op_c  = OP_READ;
        end else if (q_rop == RAW_WRITE) begin
          op_ok = 1'b1;
          op_c  = OP_WRITE;
        end else if (q_rop == RAW_DISCARD || q_rop == RAW_WRITE_ZEROES) begin
          op_ok = 1'b1;
          op_c  = OP_DISCARD;
        end
        if (!op_ok) begin
          st = (q_rop == RAW_FLUSH) ? ST_FLUSH : ST_UNSUP;
        end else if (free_count == '0 || pend_count >= N_CNT) begin
          st = ST_NO_TAG;
        end else begin
          grant     = 1'b1;
          res_tag   = tag_narrow(free_head_tag);
          res_op    = op_c;
          res_is_rw = (op_c != OP_DISCARD);
          res_pos   = pos_c;
          res_len   = q_len;
        end
      end
      CMD_PEEK: begin
        if (pend_count == '0) begin
          st = ST_EMPTY;
        end else begin
          pend_pop  = 1'b1;
          from_desc = 1'b1;
          res_tag   = tag_narrow(pend_head_tag);
        end
      end
      CMD_POP: begin
        res_tag = q_tag;
        if ({1'b0, tin_ext} < N_EXT && free_count < N_CNT) begin
          free_push = 1'b1;
        end
      end
      default: begin
        st = ST_UNSUP;
      end
    endcase
  end

  always_comb begin
    free_head_next    = free_head;
    free_tail_next    = free_tail;
    free_wrapped_next = free_wrapped;
    free_count_next   = free_count;
    pend_head_next    = pend_head;
    pend_tail_next    = pend_tail;
    pend_count_next   = pend_count;
    if (adv && grant) begin
      free_head_next  = ring_next(free_head);
      free_count_next = free_count - 1'b1;
      pend_tail_next  = ring_next(pend_tail);
      pend_count_next = pend_count + 1'b1;
    end
    if (adv && pend_pop) begin
      pend_head_next  = ring_next(pend_head);
      pend_count_next = pend_count - 1'b1;
    end
    if (adv && free_push) begin
      free_tail_next  = ring_next(free_tail);
      free_count_next = free_count + 1'b1;
      if (free_tail == LAST_IDX) begin
        free_wrapped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head    <= '0;
      free_tail    <= '0;
      free_wrapped <= 1'b0;
      free_count   <= N_CNT;
      pend_head    <= '0;
      pend_tail    <= '0;
      pend_count   <= '0;
    end else begin
      free_head    <= free_head_next;
      free_tail    <= free_tail_next;
      free_wrapped <= free_wrapped_next;
      free_count   <= free_count_next;
      pend_head    <= pend_head_next;
      pend_tail    <= pend_tail_next;
      pend_count   <= pend_count_next;
    end
  end

  brtq_tag_ring #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW),
    .DW    (IW)
  ) u_free_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (adv && free_push),
    .waddr (free_tail),
    .wdata (tin_ext[IW-1:0]),
    .raddr (free_head_next),
    .rdata (free_rdata)
  );

  brtq_tag_ring #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW),
    .DW    (IW)
  ) u_pend_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (adv && grant),
    .waddr (pend_tail),
    .wdata (free_head_tag),
    .raddr (pend_head_next),
    .rdata (pend_head_tag)
  );

  desc_t desc_wr;
  desc_t desc_rd;

  assign desc_wr.op  = op_c;
  assign desc_wr.pos = pos_c;
  assign desc_wr.len = q_len;

  brtq_desc_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_desc (
    .clk   (clk),
    .we    (adv && grant),
    .waddr (free_head_tag),
    .wdata (desc_wr),
    .re    (adv),
    .raddr (pend_head_tag),
    .rdata (desc_rd)
  );

  // result register
  status_t          r_status;
  logic [TAG_W-1:0] r_tag;
  logic             r_from_desc;
  logic [1:0]       r_op;
  logic             r_is_rw;
  logic [POS_W-1:0] r_pos;
  logic [LEN_W-1:0] r_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= 1'b1;
    end else if (rsp.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_status    <= st;
      r_tag       <= res_tag;
      r_from_desc <= from_desc;
      r_op        <= res_op;
      r_is_rw     <= res_is_rw;
      r_pos       <= res_pos;
      r_len       <= res_len;
    end
  end

  assign rsp.valid           = s2_valid;
  assign rsp.status          = r_status;
  assign rsp.tag_out         = r_tag;
  assign rsp.op_out          = r_from_desc ? desc_rd.op : r_op;
  assign rsp.is_rw           = r_from_desc ? (desc_rd.op == OP_READ || desc_rd.op == OP_WRITE)
                                           : r_is_rw;
  assign rsp.block_pos       = r_from_desc ? desc_rd.pos : r_pos;
  assign rsp.byte_length_out = r_from_desc ? desc_rd.len : r_len;

  `BRTQ_ASSERT_NOW(a_free_tag, free_count != '0, {1'b0, free_head_tag} < N_CNT, "free tag")
  `BRTQ_ASSERT_NOW(a_pend_ptrs, pend_count == '0, pend_head == pend_tail, "pend ptrs")
  `BRTQ_ASSERT_NEXT(a_push, adv && grant, s2_valid && r_status == ST_OK && |pend_count, "push")
  `BRTQ_ASSERT_NEXT(a_counts_hold, !adv, $stable(free_count) && $stable(pend_count), "count")

endmodule

`default_nettype wire

// ===== rtl/brtq_tag_ring.sv =====
`default_nettype none

module brtq_tag_ring #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] byp_data;
  logic          byp;

  // head entry is prefetched at the next read address; same-cycle write bypasses
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q     <= mem[raddr];
    byp_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= we && (waddr == raddr);
    end
  end

  assign rdata = byp ? byp_data : rd_q;

endmodule

`default_nettype wire

// ===== rtl/brtq_desc_store.sv =====
`default_nettype none

module brtq_desc_store import brtq_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  desc_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output desc_t         rdata
);

  desc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
